/* rtl/ssds_pkg.sv */
// ----------------------------------------------------------------------------
// ssds_pkg
// Shared widths, defaults and types of the step/direction sequencer.
// ----------------------------------------------------------------------------
package ssds_pkg;

	localparam int DATA_W          = 32;
	localparam int MOTOR_W         = 2;
	localparam int MASK_W          = 3;
	localparam int NUM_MOTORS_DEF  = 3;
	localparam int QUEUE_DEPTH_DEF = 8;

	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] sum;
		logic              carry;
	} alu_rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0] steps;
		logic [DATA_W-1:0] interval;
		logic [DATA_W-1:0] tag;
	} cmd_t;

endpackage

/* rtl/stepper_step_dir_sequencer_top.sv */
// ----------------------------------------------------------------------------
// stepper_step_dir_sequencer_top
// Multi-motor step/direction generator with per-motor command queues.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): req_type 1 enqueues a command for
// target_motor and yields one result with accepted set if it was stored.
// req_type 0 is a tick carrying time_now and yields one result per motor,
// in motor order, with last set on the final one.
// Output channel (out_valid/out_ready): one registered result per transfer.
// Config channel (cfg_valid/cfg_data): enable mask, always ready.
// Datapath: one 32-bit adder does the time and step-count arithmetic
// under a small sequencer; queue pointers and fill counts use separate logic.
// An enqueue passes the enqueue and output steps before its result is
// registered. A tick visits each motor in steps (elapsed time, compare,
// optional step, optional load, output). in_ready is high only when
// idle; the next item is taken while the last result still waits in the
// output register. A stalled receiver holds the sequencer at its output
// step.
// Reset clears motor state, queue pointers and the mask; the command
// store is not cleared, unread entries are guarded by the fill counts.
// ----------------------------------------------------------------------------
module stepper_step_dir_sequencer_top
	import ssds_pkg::*;
#(
	parameter int NUM_MOTORS  = NUM_MOTORS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [MASK_W-1:0]        cfg_data,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [DATA_W-1:0]        time_now,
	input  logic [MOTOR_W-1:0]       target_motor,
	input  logic signed [DATA_W-1:0] cmd_steps,
	input  logic [DATA_W-1:0]        cmd_interval,
	input  logic [DATA_W-1:0]        cmd_tag,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [MOTOR_W-1:0]       motor_index,
	output logic                     step_level,
	output logic                     dir_level,
	output logic                     started_valid,
	output logic [DATA_W-1:0]        started_tag,
	output logic                     accepted,
	output logic                     last
);

	localparam int MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = QPTR_W + 1;
	localparam int ADDR_W = MIDX_W + QPTR_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ENQ  = 3'd1;
	localparam logic [2:0] ST_ELAP = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_STEP = 3'd4;
	localparam logic [2:0] ST_LOAD = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]        state_q;
	logic [MASK_W-1:0] mask_q;
	logic [MIDX_W-1:0] cur_q;

	logic [DATA_W-1:0] last_q  [NUM_MOTORS];
	logic [DATA_W-1:0] ivl_q   [NUM_MOTORS];
	logic [DATA_W-1:0] steps_q [NUM_MOTORS];
	logic              step_q  [NUM_MOTORS];
	logic              dir_q   [NUM_MOTORS];
	logic [QPTR_W-1:0] head_q  [NUM_MOTORS];
	logic [CNT_W-1:0]  cnt_q   [NUM_MOTORS];

	logic              is_enq_q;
	logic [DATA_W-1:0] now_q;
	logic [MOTOR_W-1:0] tm_q;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] elap_q;
	logic              sv_q;
	logic [DATA_W-1:0] tag_q;
	logic              acc_q;

	logic               out_valid_q;
	logic [MOTOR_W-1:0] out_motor_q;
	logic               out_step_q;
	logic               out_dir_q;
	logic               out_sv_q;
	logic [DATA_W-1:0]  out_tag_q;
	logic               out_acc_q;
	logic               out_last_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	cmd_t              rd_cmd;
	logic              mem_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [SUM_W-1:0]  slot_sum;
	logic [QPTR_W-1:0] slot;
	logic [QPTR_W-1:0] head_nxt;
	logic              tm_in_range;
	logic              cur_is_last;
	logic [2:0]        cur3;
	logic [3:0]        mask4;
	logic              cur_en;
	logic              out_load;
	logic              res_step;
	logic              res_dir;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	assign tm_in_range = (int'(tm_q) < NUM_MOTORS);
	assign cur_is_last = (cur_q == MIDX_W'(NUM_MOTORS - 1));
	assign cur3        = 3'(cur_q);
	assign mask4       = {1'b0, mask_q};
	assign cur_en      = (cur3 < 3'(MASK_W)) && mask4[cur3[1:0]];
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		slot_sum = SUM_W'(head_q[cur_q]) + SUM_W'(cnt_q[cur_q]);
		if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
			slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
		end
		slot = slot_sum[QPTR_W-1:0];
		if (head_q[cur_q] == QPTR_W'(QUEUE_DEPTH - 1)) begin
			head_nxt = '0;
		end else begin
			head_nxt = head_q[cur_q] + QPTR_W'(1);
		end
	end

	assign mem_we  = (state_q == ST_ENQ) && tm_in_range &&
	                 (cnt_q[cur_q] < CNT_W'(QUEUE_DEPTH));
	assign wr_addr = {cur_q, slot};
	assign rd_addr = {cur_q, head_q[cur_q]};

	always_comb begin
		unique case (state_q)
			ST_ELAP: begin
				alu_req.a   = now_q;
				alu_req.b   = last_q[cur_q];
				alu_req.sub = 1'b1;
			end
			ST_CMP: begin
				alu_req.a   = elap_q;
				alu_req.b   = ivl_q[cur_q];
				alu_req.sub = 1'b1;
			end
			default: begin
				alu_req.a   = steps_q[cur_q];
				alu_req.b   = DATA_W'(1);
				alu_req.sub = !steps_q[cur_q][DATA_W-1];
			end
		endcase
	end

	ssds_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ssds_cmd_mem #(
		.ADDR_W (ADDR_W)
	) u_cmd_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (wr_addr),
		.wr_data (cmd_q),
		.rd_addr (rd_addr),
		.rd_data (rd_cmd)
	);

	always_comb begin
		if (is_enq_q && !tm_in_range) begin
			res_step = 1'b0;
			res_dir  = 1'b0;
		end else begin
			res_step = step_q[cur_q];
			res_dir  = dir_q[cur_q];
		end
	end

	// sequencer and motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			for (int m = 0; m < NUM_MOTORS; m++) begin
				last_q[m]  <= '0;
				ivl_q[m]   <= '0;
				steps_q[m] <= '0;
				step_q[m]  <= 1'b0;
				dir_q[m]   <= 1'b0;
				head_q[m]  <= '0;
				cnt_q[m]   <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (req_type) begin
							cur_q   <= MIDX_W'(target_motor);
							state_q <= ST_ENQ;
						end else begin
							cur_q   <= '0;
							state_q <= ST_ELAP;
						end
					end
				end
				ST_ENQ: begin
					if (mem_we) begin
						cnt_q[cur_q] <= cnt_q[cur_q] + CNT_W'(1);
					end
					state_q <= ST_OUT;
				end
				ST_ELAP: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cur_en && alu_rsp.carry) begin
						last_q[cur_q] <= now_q;
						if (steps_q[cur_q] != '0) begin
							state_q <= ST_STEP;
						end else begin
							state_q <= ST_LOAD;
						end
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_STEP: begin
					steps_q[cur_q] <= alu_rsp.sum;
					step_q[cur_q]  <= !step_q[cur_q];
					state_q        <= ST_LOAD;
				end
				ST_LOAD: begin
					if (steps_q[cur_q] == '0 && cnt_q[cur_q] != '0) begin
						steps_q[cur_q] <= rd_cmd.steps;
						ivl_q[cur_q]   <= rd_cmd.interval;
						head_q[cur_q]  <= head_nxt;
						cnt_q[cur_q]   <= cnt_q[cur_q] - CNT_W'(1);
						if (rd_cmd.steps != '0) begin
							dir_q[cur_q] <= !rd_cmd.steps[DATA_W-1];
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						if (is_enq_q || cur_is_last) begin
							state_q <= ST_IDLE;
						end else begin
							cur_q   <= cur_q + MIDX_W'(1);
							state_q <= ST_ELAP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture, working values and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			is_enq_q       <= req_type;
			now_q          <= time_now;
			tm_q           <= target_motor;
			cmd_q.steps    <= $unsigned(cmd_steps);
			cmd_q.interval <= cmd_interval;
			cmd_q.tag      <= cmd_tag;
		end
		if (state_q == ST_ENQ) begin
			acc_q <= mem_we;
		end
		if (state_q == ST_ELAP) begin
			elap_q <= alu_rsp.sum;
			sv_q   <= 1'b0;
		end
		if (state_q == ST_LOAD && steps_q[cur_q] == '0 && cnt_q[cur_q] != '0) begin
			sv_q  <= 1'b1;
			tag_q <= rd_cmd.tag;
		end
		if (out_load) begin
			out_step_q <= res_step;
			out_dir_q  <= res_dir;
			if (is_enq_q) begin
				out_motor_q <= tm_q;
				out_sv_q    <= 1'b0;
				out_tag_q   <= '0;
				out_acc_q   <= acc_q;
				out_last_q  <= 1'b1;
			end else begin
				out_motor_q <= MOTOR_W'(cur_q);
				out_sv_q    <= sv_q;
				out_tag_q   <= sv_q ? tag_q : '0;
				out_acc_q   <= 1'b0;
				out_last_q  <= cur_is_last;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_index   = out_motor_q;
	assign step_level    = out_step_q;
	assign dir_level     = out_dir_q;
	assign started_valid = out_sv_q;
	assign started_tag   = out_tag_q;
	assign accepted      = out_acc_q;
	assign last          = out_last_q;

	a_enq_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cnt_q[cur_q] < CNT_W'(QUEUE_DEPTH)) && is_enq_q)
		else $error("command written into a full queue");

	a_accept_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (last && !started_valid))
		else $error("accepted result also reports a started command");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (is_enq_q || cur_is_last)) |=>
			(state_q == ST_IDLE) && out_valid_q && out_last_q)
		else $error("item ended without a final result");

	a_tick_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !is_enq_q && !cur_is_last) |=>
			(state_q == ST_ELAP) && (cur_q == $past(cur_q) + MIDX_W'(1)))
		else $error("tick did not advance to the next motor");

endmodule

/* rtl/ssds_alu.sv */
// ----------------------------------------------------------------------------
// ssds_alu
// Shared 32-bit add/subtract unit with carry out (carry set means a >= b
// on subtract).
// ----------------------------------------------------------------------------
module ssds_alu
	import ssds_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [DATA_W:0] total;

	always_comb begin
		total = {1'b0, req.a} + {1'b0, req.b ^ {DATA_W{req.sub}}} + {{DATA_W{1'b0}}, req.sub};
	end

	assign rsp.sum   = total[DATA_W-1:0];
	assign rsp.carry = total[DATA_W];

endmodule

/* rtl/ssds_cmd_mem.sv */
// ----------------------------------------------------------------------------
// ssds_cmd_mem
// Command queue storage for all motors, one write and one registered read
// port.
// ----------------------------------------------------------------------------
module ssds_cmd_mem
	import ssds_pkg::*;
#(
	parameter int ADDR_W = 5
)(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  cmd_t              wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output cmd_t              rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	cmd_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the step/direction sequencer. A directed table
// exercises queue fill and reject, an out-of-range motor, zero-count and
// maximum-interval commands, time wrap and disabled motors, then random
// ticks and enqueues run under several enable masks and handshake gaps.
// Every result transfer is compared with an in-bench motor model, or with the table for checked rows.
// ----------------------------------------------------------------------------
module tb;
	import ssds_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int      MOTORS      = NUM_MOTORS_DEF;
	localparam int      DEPTH       = QUEUE_DEPTH_DEF;
	localparam int      CYCLE_LIMIT = 400000;
	localparam int      DRAIN_WAIT  = 24;
	localparam int      PHASE_ITEMS = 84;
	localparam logic    REQ_TICK    = 1'b0;
	localparam logic    REQ_ENQ     = 1'b1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e          kind;
		logic               req;
		logic [MOTOR_W-1:0] motor;
		logic [DATA_W-1:0]  steps;
		logic [DATA_W-1:0]  interval;
		logic [DATA_W-1:0]  tag;
		logic [DATA_W-1:0]  now;
		logic [MASK_W-1:0]  mask;
		logic               chk;
		logic               e_acc;
		logic               e_step;
		logic               e_dir;
	} plan_row_t;

	typedef struct packed {
		logic               req;
		logic [DATA_W-1:0]  now;
		logic [MOTOR_W-1:0] motor;
		logic [DATA_W-1:0]  steps;
		logic [DATA_W-1:0]  interval;
		logic [DATA_W-1:0]  tag;
	} stim_t;

	typedef struct packed {
		logic [MOTOR_W-1:0] motor;
		logic               step;
		logic               dir;
		logic               started;
		logic [DATA_W-1:0]  tag;
		logic               acc;
		logic               lst;
	} motor_report_t;

	localparam plan_row_t PLAN [0:23] = '{
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'd2, 32'd3, 32'h0000_00A1, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'hFFFF_FFFF, 32'd0, 32'h0000_00A2, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'd0, 32'd4, 32'h0000_00A3, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'd1, 32'd0, 32'h0000_00A4, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'd3, 32'd1, 32'h0000_00A5, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'hFFFF_FFFD, 32'd2, 32'h0000_00A6, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'd1, 32'd0, 32'h0000_00A7, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'd2, 32'd0, 32'h0000_00A8, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		// queue full
		'{ROW_ITEM, REQ_ENQ, 2'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 3'd0,
			1'b1, 1'b0, 1'b0, 1'b0},
		// no such motor
		'{ROW_ITEM, REQ_ENQ, 2'd3, 32'h8000_0000, 32'd0, 32'h0000_0000, 32'd0, 3'd0,
			1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd1, 32'hFFFF_FFFE, 32'd0, 32'h0000_0011, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		// zero count held for the longest interval
		'{ROW_ITEM, REQ_ENQ, 2'd2, 32'd0, 32'hFFFF_FFFF, 32'h0000_0022, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_ENQ, 2'd2, 32'd1, 32'd0, 32'h0000_0033, 32'd0, 3'd0,
			1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_CFG, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd100, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd103, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 3'd0,
			1'b0, 1'b0, 1'b0, 1'b0},
		// elapsed wraps to the full range
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd99, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd200, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd5, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd300, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, REQ_TICK, 2'd0, 32'd0, 32'd0, 32'd0, 32'd301, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	localparam logic [MASK_W-1:0] PHASE_MASK [0:5] = '{3'd7, 3'd3, 3'd6, 3'd0, 3'd5, 3'd7};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [MASK_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic                     req_type;
	logic [DATA_W-1:0]        time_now;
	logic [MOTOR_W-1:0]       target_motor;
	logic signed [DATA_W-1:0] cmd_steps;
	logic [DATA_W-1:0]        cmd_interval;
	logic [DATA_W-1:0]        cmd_tag;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [MOTOR_W-1:0]       motor_index;
	logic                     step_level;
	logic                     dir_level;
	logic                     started_valid;
	logic [DATA_W-1:0]        started_tag;
	logic                     accepted;
	logic                     last;

	// motor model
	logic [MASK_W-1:0] enable_mask;
	logic [DATA_W-1:0] pace_last_us [MOTORS];
	logic [DATA_W-1:0] pace_interval [MOTORS];
	logic [DATA_W-1:0] edges_left [MOTORS];
	logic              step_q [MOTORS];
	logic              dir_q [MOTORS];
	cmd_t              cmd_fifo [MOTORS][DEPTH];
	int unsigned       fifo_head [MOTORS];
	int unsigned       fifo_fill [MOTORS];

	motor_report_t     expected_reports [$];
	int                mismatch_cnt;
	int                cycle_cnt = 0;
	int                send_idle = 25;
	int                recv_idle = 49;
	logic [DATA_W-1:0] clock_us;

	stepper_step_dir_sequencer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.time_now     (time_now),
		.target_motor (target_motor),
		.cmd_steps    (cmd_steps),
		.cmd_interval (cmd_interval),
		.cmd_tag      (cmd_tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.motor_index  (motor_index),
		.step_level   (step_level),
		.dir_level    (dir_level),
		.started_valid(started_valid),
		.started_tag  (started_tag),
		.accepted     (accepted),
		.last         (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL stepper_step_dir_sequencer_top");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h want %h", what, got, want);
		mismatch_cnt++;
	endtask

	always @(posedge clk) begin
		motor_report_t want;
		if (out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				flag_mismatch("unexpected result, motor", 32'(motor_index), 32'd0);
			end else begin
				want = expected_reports.pop_front();
				if (motor_index !== want.motor)
					flag_mismatch("motor_index", 32'(motor_index), 32'(want.motor));
				if (step_level !== want.step)
					flag_mismatch("step_level", 32'(step_level), 32'(want.step));
				if (dir_level !== want.dir)
					flag_mismatch("dir_level", 32'(dir_level), 32'(want.dir));
				if (started_valid !== want.started)
					flag_mismatch("started_valid", 32'(started_valid), 32'(want.started));
				if (started_tag !== want.tag)
					flag_mismatch("started_tag", started_tag, want.tag);
				if (accepted !== want.acc)
					flag_mismatch("accepted", 32'(accepted), 32'(want.acc));
				if (last !== want.lst)
					flag_mismatch("last", 32'(last), 32'(want.lst));
			end
		end
	end

	task automatic predict_motors(input stim_t s);
		motor_report_t r;
		logic [DATA_W-1:0] elapsed;
		cmd_t c;
		int m;
		if (s.req == REQ_ENQ) begin
			r = '0;
			r.motor = s.motor;
			r.lst = 1'b1;
			if (s.motor < MOTORS) begin
				m = int'(s.motor);
				r.step = step_q[m];
				r.dir = dir_q[m];
				if (fifo_fill[m] < DEPTH) begin
					cmd_fifo[m][(fifo_head[m] + fifo_fill[m]) % DEPTH] =
						'{steps: s.steps, interval: s.interval, tag: s.tag};
					fifo_fill[m]++;
					r.acc = 1'b1;
				end
			end
			expected_reports.push_back(r);
		end else begin
			for (m = 0; m < MOTORS; m++) begin
				r = '0;
				elapsed = s.now - pace_last_us[m];
				if (enable_mask[m] && elapsed >= pace_interval[m]) begin
					pace_last_us[m] = s.now;
					if (edges_left[m] != 0) begin
						step_q[m] = ~step_q[m];
						edges_left[m] = edges_left[m][DATA_W-1] ?
							edges_left[m] + 1 : edges_left[m] - 1;
					end
					if (edges_left[m] == 0 && fifo_fill[m] != 0) begin
						c = cmd_fifo[m][fifo_head[m]];
						r.started = 1'b1;
						r.tag = c.tag;
						edges_left[m] = c.steps;
						pace_interval[m] = c.interval;
						fifo_head[m] = (fifo_head[m] + 1) % DEPTH;
						fifo_fill[m]--;
						if (c.steps != 0)
							dir_q[m] = ~c.steps[DATA_W-1];
					end
				end
				r.motor = MOTOR_W'(m);
				r.step = step_q[m];
				r.dir = dir_q[m];
				r.lst = (m == MOTORS - 1);
				expected_reports.push_back(r);
			end
		end
	endtask

	task automatic send_item(input stim_t s);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		req_type <= s.req;
		time_now <= s.now;
		target_motor <= s.motor;
		cmd_steps <= s.steps;
		cmd_interval <= s.interval;
		cmd_tag <= s.tag;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		enable_mask = v;
	endtask

	function automatic stim_t random_item();
		stim_t s;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		s.now = $urandom;
		s.motor = MOTOR_W'($urandom_range(0, 3));
		s.steps = $urandom;
		s.interval = $urandom;
		s.tag = $urandom;
		if (pick < 45) begin
			s.req = REQ_TICK;
			if ($urandom_range(0, 19) == 0)
				clock_us = $urandom;
			else
				clock_us = clock_us + $urandom_range(0, 12);
			s.now = clock_us;
		end else if (pick < 90) begin
			s.req = REQ_ENQ;
			s.motor = MOTOR_W'($urandom_range(0, MOTORS - 1));
			k = int'($urandom_range(0, 12)) - 6;
			s.steps = k;
			if ($urandom_range(0, 39) != 0)
				s.interval = $urandom_range(0, 8);
		end else begin
			// noise: command for a motor that does not exist
			s.req = REQ_ENQ;
			s.motor = MOTOR_W'(3);
		end
		return s;
	endfunction

	initial begin
		stim_t s;
		motor_report_t typed;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		time_now = '0;
		target_motor = '0;
		cmd_steps = '0;
		cmd_interval = '0;
		cmd_tag = '0;
		mismatch_cnt = 0;
		clock_us = '0;
		enable_mask = '0;
		for (int m = 0; m < MOTORS; m++) begin
			pace_last_us[m] = '0;
			pace_interval[m] = '0;
			edges_left[m] = '0;
			step_q[m] = 1'b0;
			dir_q[m] = 1'b0;
			fifo_head[m] = 0;
			fifo_fill[m] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[r]) begin
			if (PLAN[r].kind == ROW_CFG) begin
				wait_drained();
				write_mask(PLAN[r].mask);
			end else begin
				s = '{req: PLAN[r].req, now: PLAN[r].now, motor: PLAN[r].motor,
					steps: PLAN[r].steps, interval: PLAN[r].interval, tag: PLAN[r].tag};
				send_item(s);
				predict_motors(s);
				if (PLAN[r].chk) begin
					typed = '{motor: PLAN[r].motor, step: PLAN[r].e_step, dir: PLAN[r].e_dir,
						started: 1'b0, tag: '0, acc: PLAN[r].e_acc, lst: 1'b1};
					expected_reports[expected_reports.size() - 1] = typed;
				end
			end
		end
		clock_us = 32'd400;

		for (int p = 0; p < 6; p++) begin
			send_idle = (p < 2) ? 25 : (p < 4) ? 49 : 0;
			recv_idle = (p < 2) ? 49 : (p < 4) ? 25 : 0;
			wait_drained();
			write_mask(PHASE_MASK[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					wait_drained();
				s = random_item();
				send_item(s);
				predict_motors(s);
			end
		end

		wait_drained();
		if (mismatch_cnt == 0) begin
			$display("PASS stepper_step_dir_sequencer_top");
		end else begin
			$display("FAIL stepper_step_dir_sequencer_top");
		end
		$finish;
	end

endmodule
